// ----- rtl/core/smoothed_rms_level_meter_unit_assert.svh -----
// Assertion macros for the smoothed RMS level meter.
// Defining NO_ASSERTIONS turns every use into empty text.
`ifndef SMOOTHED_RMS_LEVEL_METER_UNIT_ASSERT_SVH
`define SMOOTHED_RMS_LEVEL_METER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked while reset is low.
`define SRLM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Checked at every edge, reset included.
`define SRLM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define SRLM_ASSERT(name, clk, rst, prop, msg)
`define SRLM_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- rtl/core/srlm_pkg.sv -----
// Shared types, constants and helpers of the smoothed RMS level meter.
// No dependencies; used by all other files but the assertion header.
`timescale 1ns / 1ps

package srlm_pkg;

  // Sample and accumulation widths
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W - 1;
  localparam int SQ_W       = 2 * SAMPLE_W - 3;
  localparam int SUM_W      = 41;
  localparam int MAX_FRAMES = 4096;
  localparam int COUNT_W    = 13;
  localparam int FRAME_W    = 12;

  // Level widths
  localparam int LEVEL_W    = 15;
  localparam int LEVEL_MAX  = 32767;
  localparam int SCALED_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int WEIGHT_ONE = 65536;
  localparam int ROUND_HALF = 32768;

  // Iterative units
  localparam int DIV_W       = SUM_W - 1;
  localparam int DIVISOR_W   = 15;
  localparam int DIV_STEPS   = DIV_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int ROOT_W      = DIV_W / 2;
  localparam int ROOT_REM_W  = ROOT_W + 2;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

  // Buffer queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Reset values of the registers
  localparam int RST_FRAMES    = 256;
  localparam int RST_WEIGHT    = 4588;
  localparam int RST_FULL      = 5571;
  localparam int RST_THRESHOLD = 655;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [2*MAG_W-1:0]         mag_sq_t;
  typedef logic [SQ_W-1:0]            sq_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [SUM_W:0]             sum_wide_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [FRAME_W-1:0]         frame_cnt_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [SCALED_W-1:0]        scaled_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic [WEIGHT_W:0]          inv_weight_t;
  typedef logic [LEVEL_W+WEIGHT_W:0]  prod_old_t;
  typedef logic [LEVEL_W+WEIGHT_W-1:0] prod_new_t;
  typedef logic [LEVEL_W+WEIGHT_W+1:0] blend_t;
  typedef logic [DIV_W-1:0]           dividend_t;
  typedef logic [DIVISOR_W-1:0]       divisor_t;
  typedef logic [DIVISOR_W:0]         div_rem_t;
  typedef logic [DIV_CNT_W-1:0]       div_cnt_t;
  typedef logic [ROOT_W-1:0]          root_t;
  typedef logic [ROOT_REM_W-1:0]      root_rem_t;
  typedef logic [SQRT_CNT_W-1:0]      sqrt_cnt_t;
  typedef logic [Q_PTR_W-1:0]         q_ptr_t;
  typedef logic [Q_CNT_W-1:0]         q_cnt_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAMES,
    REG_WEIGHT,
    REG_FULL_SCALE,
    REG_THRESHOLD
  } cfg_reg_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_ACCUM
  } front_state_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_MEAN,
    BACK_SQRT,
    BACK_MUL,
    BACK_BLEND,
    BACK_SCALE,
    BACK_DONE
  } back_state_t;

  // One finished buffer: sum of squares and the frames it holds
  typedef struct packed {
    sum_t   sum;
    count_t count;
  } buf_t;

  // Effective configuration, out-of-range codes already folded
  typedef struct packed {
    count_t  limit;
    weight_t weight;
    level_t  full_scale;
    scaled_t threshold;
  } cfg_t;

  typedef struct packed {
    logic      start;
    dividend_t dividend;
    divisor_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic      done;
    dividend_t quotient;
  } div_rsp_t;

  // Square of a sample halved with floor rounding, in units of 2^-30
  function automatic sq_t halved_square(input sample_t s);
    sample_t h;
    mag_t    mag;
    mag_sq_t prod;
    h    = s >>> 1;
    mag  = h[SAMPLE_W-1] ? mag_t'(-h) : mag_t'(h);
    prod = mag * mag;
    return prod[SQ_W-1:0];
  endfunction

endpackage

// ----- rtl/core/srlm_frame_if.sv -----
// Stereo frame channel of the level meter: valid/ready plus two samples.
// Depends on srlm_pkg.
`timescale 1ns / 1ps

interface srlm_frame_if;
  logic                valid;
  logic                ready;
  srlm_pkg::sample_t   left_sample;
  srlm_pkg::sample_t   right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- rtl/core/srlm_level_if.sv -----
// Level result channel of the level meter: valid/ready plus result fields.
// Depends on srlm_pkg.
`timescale 1ns / 1ps

interface srlm_level_if;
  logic              valid;
  logic              ready;
  srlm_pkg::level_t  rms_level;
  srlm_pkg::level_t  smoothed_level;
  srlm_pkg::scaled_t scaled_level;
  logic              level_jump;

  modport source (output valid, output rms_level, output smoothed_level,
                  output scaled_level, output level_jump, input ready);
  modport sink   (input valid, input rms_level, input smoothed_level,
                  input scaled_level, input level_jump, output ready);
endinterface

// ----- rtl/core/srlm_fifo.sv -----
// Two-entry queue of finished buffers between front and back end.
// Depends on srlm_pkg.
`timescale 1ns / 1ps

module srlm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  srlm_pkg::buf_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output srlm_pkg::buf_t pop_data
);

  srlm_pkg::buf_t   mem [srlm_pkg::Q_DEPTH];
  srlm_pkg::q_ptr_t wr_ptr;
  srlm_pkg::q_ptr_t rd_ptr;
  srlm_pkg::q_cnt_t count;
  logic             push;
  logic             pop;

  // Handshake and head of queue
  always_comb begin
    push_ready = (count != srlm_pkg::q_cnt_t'(srlm_pkg::Q_DEPTH));
    pop_valid  = (count != '0);
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    pop_data   = mem[rd_ptr];
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srlm_pkg::q_ptr_t'(srlm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srlm_pkg::q_ptr_t'(srlm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/srlm_front.sv -----
// Front end of the level meter: takes frames, accumulates halved squares
// and hands each finished buffer to the queue. Depends on srlm_pkg, srlm_frame_if.
`timescale 1ns / 1ps

module srlm_front (
  input  logic            clk,
  input  logic            rst,
  srlm_frame_if.sink      frame,
  input  srlm_pkg::count_t limit,
  output logic            push_valid,
  input  logic            push_ready,
  output srlm_pkg::buf_t  push_data
);

  srlm_pkg::front_state_t state;
  srlm_pkg::front_state_t state_next;
  srlm_pkg::sq_t          sq_left;
  srlm_pkg::sq_t          sq_right;
  srlm_pkg::sum_t         sum;
  srlm_pkg::frame_cnt_t   frame_count;
  srlm_pkg::sum_wide_t    sum_wide;
  srlm_pkg::sum_t         sum_sat;
  srlm_pkg::count_t       count_inc;
  logic                   buf_end;

  // Saturating accumulate and buffer end test
  always_comb begin
    sum_wide  = srlm_pkg::sum_wide_t'(sum) + srlm_pkg::sum_wide_t'(sq_left)
              + srlm_pkg::sum_wide_t'(sq_right);
    sum_sat   = sum_wide[srlm_pkg::SUM_W] ? '1 : sum_wide[srlm_pkg::SUM_W-1:0];
    count_inc = srlm_pkg::count_t'(frame_count) + 1'b1;
    buf_end   = (count_inc >= limit);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      srlm_pkg::FRONT_IDLE: begin
        if (frame.valid) state_next = srlm_pkg::FRONT_ACCUM;
      end
      srlm_pkg::FRONT_ACCUM: begin
        if (!buf_end || push_ready) state_next = srlm_pkg::FRONT_IDLE;
      end
      default: state_next = srlm_pkg::FRONT_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    frame.ready     = 1'b0;
    push_valid      = 1'b0;
    push_data.sum   = sum_sat;
    push_data.count = count_inc;
    case (state)
      srlm_pkg::FRONT_IDLE:  frame.ready = 1'b1;
      srlm_pkg::FRONT_ACCUM: push_valid  = buf_end;
      default: begin
        frame.ready = 1'b0;
        push_valid  = 1'b0;
      end
    endcase
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= srlm_pkg::FRONT_IDLE;
      sum         <= '0;
      frame_count <= '0;
    end else begin
      state <= state_next;
      if (state == srlm_pkg::FRONT_ACCUM) begin
        if (!buf_end) begin
          sum         <= sum_sat;
          frame_count <= count_inc[srlm_pkg::FRAME_W-1:0];
        end else if (push_ready) begin
          sum         <= '0;
          frame_count <= '0;
        end
      end
    end
  end

  // Squares of the accepted beat
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      sq_left  <= srlm_pkg::halved_square(frame.left_sample);
      sq_right <= srlm_pkg::halved_square(frame.right_sample);
    end
  end

endmodule

// ----- rtl/core/srlm_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on srlm_pkg.
`timescale 1ns / 1ps

module srlm_divider (
  input  logic               clk,
  input  logic               rst,
  input  srlm_pkg::div_req_t req,
  output srlm_pkg::div_rsp_t rsp
);

  logic                   busy;
  logic                   done;
  srlm_pkg::div_cnt_t     cnt;
  srlm_pkg::divisor_t     rem;
  srlm_pkg::dividend_t    quo;
  srlm_pkg::divisor_t     dsor;
  srlm_pkg::div_rem_t     rem_shift;
  srlm_pkg::div_rem_t     rem_diff;
  logic                   fits;

  // One trial subtraction
  always_comb begin
    rem_shift = {rem, quo[srlm_pkg::DIV_W-1]};
    rem_diff  = rem_shift - srlm_pkg::div_rem_t'(dsor);
    fits      = (rem_shift >= srlm_pkg::div_rem_t'(dsor));
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == srlm_pkg::div_cnt_t'(srlm_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder stays below the divisor, quotient shifts in from the right
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dsor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? rem_diff[srlm_pkg::DIVISOR_W-1:0] : rem_shift[srlm_pkg::DIVISOR_W-1:0];
      quo <= {quo[srlm_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/srlm_back.sv -----
// Back end of the level meter: mean, square root, smoothing, scaling and
// jump test for each buffer; holds the result register. Depends on
// srlm_pkg, srlm_level_if, srlm_divider.
`timescale 1ns / 1ps

module srlm_back (
  input  logic            clk,
  input  logic            rst,
  input  srlm_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  srlm_pkg::buf_t  head,
  output logic            pop,
  srlm_level_if.source    level
);

  srlm_pkg::back_state_t state;
  srlm_pkg::back_state_t state_next;
  srlm_pkg::div_req_t    div_req;
  srlm_pkg::div_rsp_t    div_rsp;

  // Square root iteration
  srlm_pkg::dividend_t   sq_val;
  srlm_pkg::root_rem_t   sq_rem;
  srlm_pkg::root_t       sq_root;
  srlm_pkg::sqrt_cnt_t   sq_cnt;
  srlm_pkg::root_rem_t   rem_sh;
  srlm_pkg::root_rem_t   trial;
  srlm_pkg::root_rem_t   rem_diff;
  logic                  sq_fits;

  // Level path
  srlm_pkg::level_t      rms_clamped;
  srlm_pkg::level_t      rms;
  srlm_pkg::prod_old_t   prod_old;
  srlm_pkg::prod_new_t   prod_new;
  srlm_pkg::inv_weight_t inv_w;
  srlm_pkg::blend_t      blend_sum;
  logic [srlm_pkg::LEVEL_W+1:0] smooth_raw;
  srlm_pkg::level_t      smooth_val;
  srlm_pkg::level_t      smooth;
  srlm_pkg::scaled_t     scaled_val;
  srlm_pkg::scaled_t     scaled;
  srlm_pkg::scaled_t     diff;
  logic                  jump;
  logic                  out_free;
  logic                  load_out;

  // Kept across buffers
  srlm_pkg::level_t      smoothed_store;
  srlm_pkg::scaled_t     previous_scaled;

  // Result register
  logic                  out_valid;
  srlm_pkg::level_t      out_rms;
  srlm_pkg::level_t      out_smooth;
  srlm_pkg::scaled_t     out_scaled;
  logic                  out_jump;

  srlm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Square root step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh   = {sq_rem[srlm_pkg::ROOT_REM_W-3:0], sq_val[srlm_pkg::DIV_W-1 -: 2]};
    trial    = {sq_root, 2'b01};
    rem_diff = rem_sh - trial;
    sq_fits  = (rem_sh >= trial);
  end

  // Smoothing, scaling and jump arithmetic
  always_comb begin
    rms_clamped = (sq_root > srlm_pkg::LEVEL_MAX) ? srlm_pkg::level_t'(srlm_pkg::LEVEL_MAX)
                                                 : sq_root[srlm_pkg::LEVEL_W-1:0];
    inv_w       = srlm_pkg::inv_weight_t'(srlm_pkg::WEIGHT_ONE)
                - srlm_pkg::inv_weight_t'(cfg.weight);
    blend_sum   = srlm_pkg::blend_t'(prod_old) + srlm_pkg::blend_t'(prod_new)
                + srlm_pkg::blend_t'(srlm_pkg::ROUND_HALF);
    smooth_raw  = blend_sum[srlm_pkg::LEVEL_W+srlm_pkg::WEIGHT_W+1:srlm_pkg::WEIGHT_W];
    smooth_val  = (smooth_raw > srlm_pkg::LEVEL_MAX) ? srlm_pkg::level_t'(srlm_pkg::LEVEL_MAX)
                                                    : smooth_raw[srlm_pkg::LEVEL_W-1:0];
    scaled_val  = (|div_rsp.quotient[srlm_pkg::DIV_W-1:srlm_pkg::SCALED_W]) ? '1
                : div_rsp.quotient[srlm_pkg::SCALED_W-1:0];
    diff        = (scaled > previous_scaled) ? scaled - previous_scaled
                                             : previous_scaled - scaled;
    jump        = (diff > cfg.threshold);
    out_free    = !out_valid || level.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      srlm_pkg::BACK_IDLE:  if (head_valid) state_next = srlm_pkg::BACK_MEAN;
      srlm_pkg::BACK_MEAN:  if (div_rsp.done) state_next = srlm_pkg::BACK_SQRT;
      srlm_pkg::BACK_SQRT: begin
        if (sq_cnt == srlm_pkg::sqrt_cnt_t'(srlm_pkg::SQRT_STEPS - 1)) begin
          state_next = srlm_pkg::BACK_MUL;
        end
      end
      srlm_pkg::BACK_MUL:   state_next = srlm_pkg::BACK_BLEND;
      srlm_pkg::BACK_BLEND: state_next = srlm_pkg::BACK_SCALE;
      srlm_pkg::BACK_SCALE: if (div_rsp.done) state_next = srlm_pkg::BACK_DONE;
      srlm_pkg::BACK_DONE:  if (out_free) state_next = srlm_pkg::BACK_IDLE;
      default:              state_next = srlm_pkg::BACK_IDLE;
    endcase
  end

  // Outputs: queue pop, divider requests, result load
  always_comb begin
    pop              = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head.sum[srlm_pkg::SUM_W-1:1];
    div_req.divisor  = srlm_pkg::divisor_t'(head.count);
    case (state)
      srlm_pkg::BACK_IDLE: begin
        pop           = head_valid;
        div_req.start = head_valid;
      end
      srlm_pkg::BACK_BLEND: begin
        div_req.start    = 1'b1;
        div_req.dividend = srlm_pkg::dividend_t'({smooth_val, {srlm_pkg::SCALED_W{1'b0}}});
        div_req.divisor  = cfg.full_scale;
      end
      srlm_pkg::BACK_DONE: load_out = out_free;
      default: begin
        pop           = 1'b0;
        div_req.start = 1'b0;
      end
    endcase
  end

  assign level.valid          = out_valid;
  assign level.rms_level      = out_rms;
  assign level.smoothed_level = out_smooth;
  assign level.scaled_level   = out_scaled;
  assign level.level_jump     = out_jump;

  // Control and state kept across buffers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= srlm_pkg::BACK_IDLE;
      out_valid       <= 1'b0;
      smoothed_store  <= '0;
      previous_scaled <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid       <= 1'b1;
        smoothed_store  <= smooth;
        previous_scaled <= scaled;
      end else if (level.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      srlm_pkg::BACK_MEAN: begin
        if (div_rsp.done) begin
          sq_val  <= div_rsp.quotient;
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
        end
      end
      srlm_pkg::BACK_SQRT: begin
        sq_val  <= {sq_val[srlm_pkg::DIV_W-3:0], 2'b00};
        sq_rem  <= sq_fits ? rem_diff : rem_sh;
        sq_root <= {sq_root[srlm_pkg::ROOT_W-2:0], sq_fits};
        sq_cnt  <= sq_cnt + 1'b1;
      end
      srlm_pkg::BACK_MUL: begin
        rms      <= rms_clamped;
        prod_old <= smoothed_store * inv_w;
        prod_new <= rms_clamped * cfg.weight;
      end
      srlm_pkg::BACK_BLEND: smooth <= smooth_val;
      srlm_pkg::BACK_SCALE: begin
        if (div_rsp.done) scaled <= scaled_val;
      end
      srlm_pkg::BACK_DONE: begin
        if (out_free) begin
          out_rms    <= rms;
          out_smooth <= smooth;
          out_scaled <= scaled;
          out_jump   <= jump;
        end
      end
      default: begin
        sq_cnt <= sq_cnt;
      end
    endcase
  end

endmodule

// ----- rtl/core/smoothed_rms_level_meter_unit.sv -----
// Smoothed RMS level meter.
// Channels: "frame" takes one stereo frame per beat (left_sample,
// right_sample, signed Q1.15); "level" gives one result per buffer
// (rms_level, smoothed_level, scaled_level, level_jump). Both are
// valid/ready. Registers are written through cfg_we/cfg_index/cfg_data.
// In the accumulator the squares of a frame are registered, then added to
// the saturating 41-bit sum, so frames are not accepted back to back. At a
// buffer end the sum goes into a two-entry queue; for each buffer the back
// end makes two passes through the 40-step shared divider and one through
// the 20-step square root. With buffers shorter than 53 frames the back
// end sets the rate and the front end stalls once the queue is full.
// A buffer's result is offered once the back end has run the mean
// division, square root, smoothing and scaling division on it.
// Reset clears the sum, frame count, smoothed level, previous scaled level,
// queue and pending result, and restores the register defaults.
// When the receiver stalls, the result is held; the back end finishes the
// next buffer and waits, then the queue fills and frame stops being ready.
`timescale 1ns / 1ps
`include "smoothed_rms_level_meter_unit_assert.svh"

module smoothed_rms_level_meter_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  srlm_frame_if.sink                             frame,
  srlm_level_if.source                           level,
  input  logic                                   cfg_we,
  input  logic [srlm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [srlm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  srlm_pkg::count_t  frames_per_buffer;
  srlm_pkg::weight_t smoothing_weight;
  srlm_pkg::level_t  full_scale_level;
  srlm_pkg::scaled_t jump_threshold;
  srlm_pkg::cfg_t    cfg;

  logic              q_push_valid;
  logic              q_push_ready;
  srlm_pkg::buf_t    q_push_data;
  logic              q_avail;
  logic              q_pop;
  srlm_pkg::buf_t    q_head;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_buffer <= srlm_pkg::count_t'(srlm_pkg::RST_FRAMES);
      smoothing_weight  <= srlm_pkg::weight_t'(srlm_pkg::RST_WEIGHT);
      full_scale_level  <= srlm_pkg::level_t'(srlm_pkg::RST_FULL);
      jump_threshold    <= srlm_pkg::scaled_t'(srlm_pkg::RST_THRESHOLD);
    end else if (cfg_we) begin
      case (srlm_pkg::cfg_reg_t'(cfg_index))
        srlm_pkg::REG_FRAMES:     frames_per_buffer <= cfg_data[srlm_pkg::COUNT_W-1:0];
        srlm_pkg::REG_WEIGHT:     smoothing_weight  <= cfg_data;
        srlm_pkg::REG_FULL_SCALE: full_scale_level  <= cfg_data[srlm_pkg::LEVEL_W-1:0];
        srlm_pkg::REG_THRESHOLD:  jump_threshold    <= cfg_data;
        default:                  jump_threshold    <= jump_threshold;
      endcase
    end
  end

  // Zero frames or full scale act as one; over 4096 frames act as 4096
  always_comb begin
    if (frames_per_buffer == '0) begin
      cfg.limit = srlm_pkg::count_t'(1);
    end else if (frames_per_buffer > srlm_pkg::MAX_FRAMES) begin
      cfg.limit = srlm_pkg::count_t'(srlm_pkg::MAX_FRAMES);
    end else begin
      cfg.limit = frames_per_buffer;
    end
    cfg.weight     = smoothing_weight;
    cfg.full_scale = (full_scale_level == '0) ? srlm_pkg::level_t'(1) : full_scale_level;
    cfg.threshold  = jump_threshold;
  end

  srlm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .limit      (cfg.limit),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  srlm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_avail),
    .pop_ready  (q_pop),
    .pop_data   (q_head)
  );

  srlm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_avail),
    .head       (q_head),
    .pop        (q_pop),
    .level      (level)
  );

  // Checks
  `SRLM_ASSERT(a_frame_gap, clk, rst, frame.valid && frame.ready |=> !frame.ready, "frame taken on back-to-back cycles")
  `SRLM_ASSERT(a_pop_nonempty, clk, rst, q_pop |-> q_avail, "buffer queue popped while empty")
  `SRLM_ASSERT(a_push_hold, clk, rst, q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data), "stalled buffer changed before queue took it")
  `SRLM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !level.valid, "result pending right after reset")

endmodule
